### hw/rtl/grq_pkg.sv
package grq_pkg;

   localparam int VERTEX_FIELD_W = 6;
   localparam int VERTEX_COUNT_W = 7;
   localparam logic [VERTEX_COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]                kind;
      logic [VERTEX_FIELD_W-1:0] src_vertex;
      logic [VERTEX_FIELD_W-1:0] dst_vertex;
   } req_type;

   typedef struct packed {
      logic direct_edge;
      logic reachable;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_A,
      ST_ADD_B,
      ST_Q_SRC,
      ST_Q_ROW,
      ST_Q_PUSH,
      ST_Q_POP
   } state_type;

endpackage

### hw/rtl/grq_ram.sv
module grq_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/graph_reachability_query.sv
// Channel   Ports                          Request moves when
// --------  -----------------------------  ---------------------------------
// input     start, busy, req_item          start high and busy low
// result    rsp_strobe, rsp_item           rsp_strobe high (one cycle, no stall)
// csr       csr_valid, csr_ready, csr_data csr_valid high (csr_ready tied high)
//
// Add edge: ST_ADD_A, then ST_ADD_B unless a self loop; out-of-range items: ST_IDLE only.
// Clear: ST_CLEAR over all MAX_VERTICES rows, one adjacency row zeroed per cycle.
// Query: the source row is read in ST_Q_SRC, each pending vertex is pushed in
// ST_Q_PUSH and each popped vertex passes ST_Q_POP and ST_Q_ROW, all through
// the single adjacency read port.
// Reset runs the same row sweep, with busy high.
// Results are registered and never held back.
module graph_reachability_query
   import grq_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_item,
   output logic                      rsp_strobe,
   output rsp_type                   rsp_item,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [VERTEX_COUNT_W-1:0] csr_data
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int MW = $clog2(MAX_VERTICES + 1);
   localparam int CW = (MW > VERTEX_COUNT_W) ? MW : VERTEX_COUNT_W;
   localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

   state_type state_ff, state_in;
   logic [VERTEX_COUNT_W-1:0] vc_ff;
   logic [VW-1:0] src_ff, src_in, dst_ff, dst_in, clr_ff, clr_in;
   logic [MW-1:0] depth_ff, depth_in, depth_dec;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in, pending_ff, pending_in;
   logic direct_ff, direct_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_item_ff, rsp_item_in;

   logic [CW-1:0] lim;
   logic [MAX_VERTICES-1:0] lim_mask, low_bit;
   logic [VW-1:0] low_idx, req_src, req_dst;
   logic ok;

   logic adj_we;
   logic [VW-1:0] adj_waddr, adj_raddr;
   logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
   logic stk_we;
   logic [VW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

   grq_ram #(.DEPTH(MAX_VERTICES), .WIDTH(MAX_VERTICES)) u_adj (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   grq_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // usable vertex count and its mask
   assign lim = (CW'(vc_ff) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vc_ff);

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         lim_mask[i] = CW'(i) < lim;
      end
   end

   // lowest pending vertex
   assign low_bit = pending_ff & (~pending_ff + ONE);

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | VW'(i);
         end
      end
   end

   assign req_src   = VW'(req_item.src_vertex);
   assign req_dst   = VW'(req_item.dst_vertex);
   assign ok        = (CW'(req_item.src_vertex) < lim) && (CW'(req_item.dst_vertex) < lim);
   assign depth_dec = depth_ff - MW'(1);

   always_comb begin
      state_in      = state_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      clr_in        = clr_ff;
      depth_in      = depth_ff;
      visited_in    = visited_ff;
      pending_in    = pending_ff;
      direct_in     = direct_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      adj_we        = 1'b0;
      adj_waddr     = clr_ff;
      adj_wdata     = '0;
      adj_raddr     = req_src;
      stk_we        = 1'b0;
      stk_waddr     = depth_ff[VW-1:0];
      stk_wdata     = low_idx;
      stk_raddr     = depth_dec[VW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_item.kind)
                  KIND_ADD: begin
                     if (ok) begin
                        src_in   = req_src;
                        dst_in   = req_dst;
                        state_in = ST_ADD_A;
                     end
                  end
                  KIND_QUERY: begin
                     if (ok) begin
                        src_in     = req_src;
                        dst_in     = req_dst;
                        visited_in = ONE << req_src;
                        depth_in   = '0;
                        state_in   = ST_Q_SRC;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_item_in   = '0;
                     end
                  end
                  KIND_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            adj_we    = 1'b1;
            adj_waddr = clr_ff;
            adj_wdata = '0;
            if (clr_ff == VW'(MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + VW'(1);
            end
         end
         ST_ADD_A: begin
            adj_we    = 1'b1;
            adj_waddr = src_ff;
            adj_wdata = adj_rdata | (ONE << dst_ff);
            adj_raddr = dst_ff;
            state_in  = (src_ff == dst_ff) ? ST_IDLE : ST_ADD_B;
         end
         ST_ADD_B: begin
            adj_we    = 1'b1;
            adj_waddr = dst_ff;
            adj_wdata = adj_rdata | (ONE << src_ff);
            state_in  = ST_IDLE;
         end
         ST_Q_SRC, ST_Q_ROW: begin
            pending_in = adj_rdata & ~visited_ff & lim_mask;
            if (state_ff == ST_Q_SRC) begin
               direct_in = adj_rdata[dst_ff];
            end
            state_in = ST_Q_PUSH;
         end
         ST_Q_PUSH: begin
            if (pending_ff != '0) begin
               stk_we     = 1'b1;
               depth_in   = depth_ff + MW'(1);
               visited_in = visited_ff | low_bit;
               pending_in = pending_ff & ~low_bit;
            end else if (depth_ff == '0) begin
               rsp_strobe_in         = 1'b1;
               rsp_item_in.direct_edge = direct_ff;
               rsp_item_in.reachable   = visited_ff[dst_ff];
               state_in              = ST_IDLE;
            end else begin
               depth_in = depth_dec;
               state_in = ST_Q_POP;
            end
         end
         ST_Q_POP: begin
            adj_raddr = stk_rdata;
            state_in  = ST_Q_ROW;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         depth_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         vc_ff         <= VERTEX_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         depth_ff      <= depth_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            vc_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      visited_ff  <= visited_in;
      pending_ff  <= pending_in;
      direct_ff   <= direct_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

### hw/rtl/grq_checker.sv
module grq_checker
   import grq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // a neighbour is always reachable
   a_direct_reach: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.direct_edge |-> rsp_item.reachable)
      else $error("direct edge reported without reachability");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   a_no_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.kind != KIND_QUERY) |=> !rsp_strobe)
      else $error("result for a request that is not a query");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.kind == KIND_CLEAR) |=> busy)
      else $error("clear request did not start the row sweep");

   a_reset_sweep: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> busy)
      else $error("no row sweep after reset");

endmodule

bind graph_reachability_query grq_checker u_grq_checker (.*);

### verif/testbench.sv
import grq_pkg::*;

class reach_checker;
   logic [63:0] adjacency [64];
   logic [6:0]  vertex_count;
   rsp_type     pending_answers [$];
   int          failures;
   int          requests;
   int          queries;
   int          reached;

   function new();
      clear_graph();
      vertex_count = VERTEX_COUNT_RESET;
      failures = 0;
      requests = 0;
      queries = 0;
      reached = 0;
   endfunction

   function void clear_graph();
      foreach (adjacency[i]) adjacency[i] = '0;
   endfunction

   function int usable_count();
      return (vertex_count > 64) ? 64 : int'(vertex_count);
   endfunction

   // flood fill over the vertices in use; a vertex always reaches itself
   function logic flood_reach(int from, int target, int lim);
      logic [63:0] seen;
      logic [63:0] grown;
      logic [63:0] in_use;
      in_use = (lim >= 64) ? '1 : ((64'd1 << lim) - 64'd1);
      seen = 64'd1 << from;
      forever begin
         grown = seen;
         for (int v = 0; v < 64; v++) begin
            if (seen[v]) grown |= adjacency[v] & in_use;
         end
         if (grown == seen) break;
         seen = grown;
      end
      return seen[target];
   endfunction

   function void note_request(req_type r);
      int      lim;
      logic    in_range;
      rsp_type answer;
      lim = usable_count();
      in_range = (r.src_vertex < lim) && (r.dst_vertex < lim);
      requests++;
      case (r.kind)
         KIND_ADD: begin
            if (in_range) begin
               adjacency[r.src_vertex][r.dst_vertex] = 1'b1;
               adjacency[r.dst_vertex][r.src_vertex] = 1'b1;
            end
         end
         KIND_CLEAR: begin
            clear_graph();
         end
         KIND_QUERY: begin
            answer = '0;
            if (in_range) begin
               answer.direct_edge = adjacency[r.src_vertex][r.dst_vertex];
               answer.reachable = flood_reach(r.src_vertex, r.dst_vertex, lim);
            end
            pending_answers.push_back(answer);
            queries++;
            if (answer.reachable) reached++;
         end
         default: begin
         end
      endcase
   endfunction

   function void check_answer(rsp_type got);
      rsp_type want;
      if (pending_answers.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("ERROR: answer %b/%b with no query outstanding",
                     got.direct_edge, got.reachable);
         return;
      end
      want = pending_answers.pop_front();
      if (got.direct_edge !== want.direct_edge || got.reachable !== want.reachable) begin
         failures++;
         if (failures <= 10)
            $display("ERROR: direct_edge exp %b got %b, reachable exp %b got %b",
                     want.direct_edge, got.direct_edge, want.reachable, got.reachable);
      end
   endfunction

   function void close();
      if (pending_answers.size() != 0) begin
         failures += pending_answers.size();
         $display("ERROR: %0d queries never answered", pending_answers.size());
      end
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 300;
   localparam int PHASE_ITEMS = 260;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   req_type                   req_item;
   logic                      rsp_strobe;
   rsp_type                   rsp_item;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [VERTEX_COUNT_W-1:0] csr_data;

   reach_checker book;
   int           idle_cycles = 0;
   int           burst_left = 0;
   bit           steady = 0;
   int           settings_used = 0;

   graph_reachability_query DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) book.check_answer(rsp_item);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_req(logic [1:0] kind, int a, int b);
      req_type r;
      r.kind = kind;
      r.src_vertex = a[VERTEX_FIELD_W-1:0];
      r.dst_vertex = b[VERTEX_FIELD_W-1:0];
      return r;
   endfunction

   function automatic req_type random_request(int span);
      int          roll;
      logic [1:0]  kind;
      int          a;
      int          b;
      roll = $urandom_range(0, 99);
      if (roll < 50) kind = KIND_ADD;
      else if (roll < 93) kind = KIND_QUERY;
      else if (roll < 97) kind = KIND_CLEAR;
      else kind = KIND_UNUSED;
      a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, span - 1);
      b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, span - 1);
      return make_req(kind, a, b);
   endfunction

   // called at a rising edge; returns at the edge that takes the request
   task automatic send_request(input req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = steady ? 1000000 : $urandom_range(1, 12);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left = burst_left - 1;
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      book.note_request(r);
   endtask

   task automatic settle();
      start <= 1'b0;
      burst_left = 0;
      while (book.pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [VERTEX_COUNT_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      book.vertex_count = value;
      settings_used++;
   endtask

   initial begin
      logic [VERTEX_COUNT_W-1:0] counts [8];
      int                        lim;
      int                        span;
      int                        items;

      book = new();
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: default count
      send_request(make_req(KIND_ADD, 0, 63));
      send_request(make_req(KIND_QUERY, 0, 63));
      send_request(make_req(KIND_QUERY, 63, 0));
      send_request(make_req(KIND_ADD, 63, 62));
      send_request(make_req(KIND_QUERY, 0, 62));
      send_request(make_req(KIND_ADD, 5, 5));
      send_request(make_req(KIND_QUERY, 5, 5));
      send_request(make_req(KIND_QUERY, 7, 7));
      send_request(make_req(KIND_QUERY, 10, 11));
      send_request(make_req(KIND_UNUSED, 63, 0));
      send_request(make_req(KIND_ADD, 62, 40));
      send_request(make_req(KIND_QUERY, 40, 0));
      send_request(make_req(KIND_CLEAR, 0, 0));
      send_request(make_req(KIND_QUERY, 0, 63));
      send_request(make_req(KIND_QUERY, 5, 5));
      // lowered count hides stored edges to vertex 40
      send_request(make_req(KIND_ADD, 0, 40));
      send_request(make_req(KIND_ADD, 40, 2));
      write_count(7'd10);
      send_request(make_req(KIND_QUERY, 0, 2));
      send_request(make_req(KIND_QUERY, 0, 40));
      send_request(make_req(KIND_ADD, 10, 1));
      send_request(make_req(KIND_ADD, 1, 9));
      send_request(make_req(KIND_QUERY, 1, 9));
      write_count(7'd0);
      send_request(make_req(KIND_ADD, 0, 0));
      send_request(make_req(KIND_QUERY, 0, 0));

      counts = '{7'd64, 7'd12, 7'd127, 7'd1, 7'd0, 7'd40, 7'd5, 7'd2};
      counts[7] = 7'($urandom_range(2, 64));
      for (int phase = 0; phase < 8; phase++) begin
         write_count(counts[phase]);
         steady = (phase % 3 == 1);
         lim = book.usable_count();
         span = (lim == 0) ? 64 : $urandom_range(1, lim);
         items = (lim == 0) ? 40 : PHASE_ITEMS;
         for (int n = 0; n < items; n++) send_request(random_request(span));
      end

      settle();
      book.close();
      $display("Ran %0d requests across %0d vertex-count settings (0, 1, 64, 127 among them).",
               book.requests, settings_used);
      $display("%0d queries answered, %0d of them reachable; %0d failures.",
               book.queries, book.reached, book.failures);
      if (book.failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/grq_pkg.sv
hw/rtl/grq_ram.sv
hw/rtl/graph_reachability_query.sv
hw/rtl/grq_checker.sv
verif/testbench.sv
